>>> rtl/ternary_weight_dot_product_top_macros.svh
// Assertion macros for the ternary weight dot product block.
// Included by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef TERNARY_WEIGHT_DOT_PRODUCT_TOP_MACROS_SVH
`define TERNARY_WEIGHT_DOT_PRODUCT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TWDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TWDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TWDP_ASSERT_NOW(lbl, ante, cons, msg)
`define TWDP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/twdp_pkg.sv
// Shared types, constants and functions for the ternary weight dot product block.
// No dependencies; imported by twdp_dot, ternary_weight_dot_product_top and the testbench.
package twdp_pkg;

    localparam int unsigned MAX_VECTOR_LEN = 8192;

    localparam int unsigned ADDR_W = 3;
    localparam logic [31:0] SCALE_RESET = 32'd65536;

    // Register index, taken from paddr[2]
    localparam logic REG_SCALE   = 1'b0;
    localparam logic REG_BIAS_EN = 1'b1;

    // Weight codes (weight = code - 1)
    localparam logic [1:0] CODE_NEG  = 2'd0;
    localparam logic [1:0] CODE_ZERO = 2'd1;
    localparam logic [1:0] CODE_POS  = 2'd2;
    localparam logic [1:0] CODE_TWO  = 2'd3;

    typedef struct packed {
        logic [7:0]         weight_byte;
        logic signed [7:0]  act_a;
        logic signed [7:0]  act_b;
        logic signed [7:0]  act_c;
        logic signed [7:0]  act_d;
        logic signed [31:0] bias_value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] dot_sum;
        logic signed [63:0] scaled_result;
    } result_t;

    typedef struct packed {
        logic accept;
        logic last;
    } acc_ctrl_t;

    // One ternary product: weight in {-1, 0, +1, +2} times a signed byte
    function automatic logic signed [9:0] tern_prod(input logic [1:0] code,
                                                    input logic signed [7:0] act);
        logic signed [9:0] ext;
        logic signed [9:0] prod;
        begin
            ext = {{2{act[7]}}, act};
            unique case (code)
                CODE_NEG:  prod = -ext;
                CODE_ZERO: prod = '0;
                CODE_POS:  prod = ext;
                CODE_TWO:  prod = ext <<< 1;
                default:   prod = '0;
            endcase
            return prod;
        end
    endfunction

endpackage

>>> rtl/ternary_weight_dot_product_top.sv
// Top level of the ternary weight dot product block: APB registers,
// accumulate stage, multiply stage and bias/saturate output stage.
// Depends on twdp_pkg, twdp_dot and ternary_weight_dot_product_top_macros.svh.
//
// Usage:
//   Stream items on item/item_valid/item_ready. Each item holds one weight
//   byte (four 2-bit codes, weight = code - 1) and four int8 activations.
//   Every item is folded into a 32-bit wrapping accumulator as it is taken.
//   The item with last set closes the vector: one result (raw dot_sum and
//   dot_sum * scale_q16 + optional bias, saturated to 64 bits) leaves on
//   result/result_valid/result_ready, and the accumulator clears.
//   Throughput: one item per cycle while item_ready is high. The last item's
//   sum then passes the stage registers in order (accumulate, 32x33
//   multiply, bias add with saturation, one register each) to the result.
//   When result_ready is low, the output register holds; the inner stages
//   fill up, and item_ready drops only once every stage holds a result.
//   Items that are not last never occupy a stage, so they keep flowing until every stage holds a result.
//   Reset (rst_n low, asynchronous) clears the accumulator, empties all stages,
//   and sets scale_q16 to 1.0 (0x00010000) and bias_enable to 0.
//   Registers: scale_q16 at 0x0, bias_enable at 0x4; write only while idle.
module ternary_weight_dot_product_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            item_valid,
    output logic                            item_ready,
    input  twdp_pkg::item_t                 item,
    // result channel
    output logic                            result_valid,
    input  logic                            result_ready,
    output twdp_pkg::result_t               result,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [twdp_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import twdp_pkg::*;

    `include "ternary_weight_dot_product_top_macros.svh"

    // ---------------- configuration registers ----------------
    logic [31:0] scale_reg;
    logic        bias_en_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= SCALE_RESET;
            bias_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCALE:   scale_reg   <= pwdata;
                REG_BIAS_EN: bias_en_reg <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SCALE:   prdata = scale_reg;
            REG_BIAS_EN: prdata = {31'd0, bias_en_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- stage advance chain ----------------
    // A stage moves when it is empty or the stage after it moves.
    logic a_valid_reg;
    logic b_valid_reg;
    logic res_valid_reg;
    logic res_adv;
    logic b_adv;
    logic a_adv;
    logic item_accept;

    assign res_adv     = !res_valid_reg || result_ready;
    assign b_adv       = !b_valid_reg || res_adv;
    assign a_adv       = !a_valid_reg || b_adv;
    assign item_ready  = a_adv;
    assign item_accept = item_valid && item_ready;

    // ---------------- accumulate ----------------
    acc_ctrl_t          acc_ctrl;
    logic signed [31:0] run_sum;

    assign acc_ctrl.accept = item_accept;
    assign acc_ctrl.last   = item.last;

    twdp_dot u_dot (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .item  (item),
        .sum   (run_sum)
    );

    // Stage A: the closed vector sum and its bias
    logic signed [31:0] a_sum_reg;
    logic signed [31:0] a_bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= item_accept && item.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && item_accept && item.last)
        begin
            a_sum_reg  <= run_sum;
            a_bias_reg <= item.bias_value;
        end
    end

    // ---------------- multiply ----------------
    // Signed sum times unsigned scale; |product| < 2^63, so 64 bits hold it.
    logic signed [64:0] mult_full;
    logic signed [31:0] b_sum_reg;
    logic signed [63:0] b_prod_reg;
    logic signed [31:0] b_bias_reg;

    assign mult_full = a_sum_reg * $signed({1'b0, scale_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
        begin
            b_sum_reg  <= a_sum_reg;
            b_prod_reg <= mult_full[63:0];
            b_bias_reg <= a_bias_reg;
        end
    end

    // ---------------- bias add and saturate ----------------
    logic signed [64:0] biased;
    logic signed [63:0] scaled;
    result_t            res_reg;

    assign biased = {b_prod_reg[63], b_prod_reg} + {{33{b_bias_reg[31]}}, b_bias_reg};

    always_comb
    begin
        scaled = b_prod_reg;
        if (bias_en_reg)
        begin
            priority if (biased[64] != biased[63])
            begin
                // clamp to the limit on the side of the true sign
                scaled = biased[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                scaled = biased[63:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_adv)
        begin
            res_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_adv && b_valid_reg)
        begin
            res_reg.dot_sum       <= b_sum_reg;
            res_reg.scaled_result <= scaled;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // ---------------- assertions ----------------
    `TWDP_ASSERT_NOW(a_empty_out_ready, !res_valid_reg, item_ready,
        "item_ready low while the output stage is empty")
    `TWDP_ASSERT_NEXT(a_stage_hold, a_valid_reg && !b_adv,
        a_valid_reg && $stable(a_sum_reg),
        "stage A lost or changed a held sum")
    `TWDP_ASSERT_NEXT(b_stage_hold, b_valid_reg && !res_adv,
        b_valid_reg && $stable(b_prod_reg),
        "stage B lost or changed a held product")
    `TWDP_ASSERT_NEXT(a_no_result_from_plain, !a_valid_reg && !(item_accept && item.last),
        !a_valid_reg, "stage A filled without a last item")

endmodule

>>> rtl/twdp_dot.sv
// Four ternary products, their sum and the 32-bit wrapping accumulator.
// Depends on twdp_pkg.
module twdp_dot (
    input  logic                clk,
    input  logic                rst_n,
    input  twdp_pkg::acc_ctrl_t ctrl,
    input  twdp_pkg::item_t     item,
    output logic signed [31:0]  sum
);
    import twdp_pkg::*;

    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic signed [11:0] part;

    assign part = 12'(tern_prod(item.weight_byte[7:6], item.act_a))
                + 12'(tern_prod(item.weight_byte[5:4], item.act_b))
                + 12'(tern_prod(item.weight_byte[3:2], item.act_c))
                + 12'(tern_prod(item.weight_byte[1:0], item.act_d));

    // Running sum including the current item; wraps modulo 2^32
    assign sum = acc_reg + 32'(part);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.accept)
        begin
            acc_next = ctrl.last ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

>>> tb/sv/tb_ternary_weight_dot_product_top.sv
// Testbench for ternary_weight_dot_product_top: drives items, programs the registers over
// APB and checks every result against a built-in predictor or a typed-in result of the plan.
// Depends on twdp_pkg and the RTL of ternary_weight_dot_product_top.
module tb_ternary_weight_dot_product_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twdp_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;   // three pipeline registers plus one spare

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SAT_MIN = 64'sh8000_0000_0000_0000;

    // One row of the directed plan: register setting, item, and optionally a
    // typed-in result that replaces the predicted one.
    typedef struct {
        logic [31:0] scale;
        logic        bias_on;
        item_t       it;
        bit          pinned;
        result_t     res;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    item_t               item;
    logic                result_valid;
    logic                result_ready;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Travels alongside item so the monitor sees the matching pin at acceptance.
    bit                  pin_use;
    result_t             pin_res;

    // Predictor state: running vector sum and our copy of the registers.
    logic [31:0]         run_sum;
    logic [31:0]         cfg_scale;
    logic                cfg_bias_on;
    result_t             sums_due[$];

    int                  mismatches;
    int                  sent;
    bit                  quiet;      // no idling on either side
    bit                  burst_on;   // set once the sender starts one-item vectors for the stall test; stays set

    ternary_weight_dot_product_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Sum of the four ternary products of one item. Weight is code minus one,
    // so code three really is +2.
    function automatic logic [31:0] group_sum(item_t it);
        int acts[4];
        int total;
        int w;
        acts[0] = int'(it.act_a);
        acts[1] = int'(it.act_b);
        acts[2] = int'(it.act_c);
        acts[3] = int'(it.act_d);
        total = 0;
        for (int k = 0; k < 4; k++)
        begin
            w = int'(it.weight_byte[7-2*k -: 2]) - 1;
            total += w * acts[k];
        end
        return total;
    endfunction

    // Wrapped vector sum times the unsigned Q16.16 scale, plus the bias when
    // enabled, clipped to the signed 64-bit range.
    function automatic logic signed [63:0] scale_sum(logic [31:0] acc, logic [31:0] bias_bits);
        longint prod;
        longint bias;
        longint res;
        prod = longint'(signed'(acc)) * longint'({32'b0, cfg_scale});
        res  = prod;
        if (cfg_bias_on)
        begin
            bias = longint'(signed'(bias_bits));
            if (bias > 0 && prod > SAT_MAX - bias)
                res = SAT_MAX;
            else if (bias < 0 && prod < SAT_MIN - bias)
                res = SAT_MIN;
            else
                res = prod + bias;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check results first, then fold in the accepted item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        logic [31:0] nxt;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("unexpected result: dot_sum %0d scaled_result %0d",
                           result.dot_sum, result.scaled_result);
                    mismatches++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (result.dot_sum !== want.dot_sum)
                    begin
                        $error("dot_sum: expected %0d, got %0d", want.dot_sum, result.dot_sum);
                        mismatches++;
                    end
                    if (result.scaled_result !== want.scaled_result)
                    begin
                        $error("scaled_result: expected %0d, got %0d",
                               want.scaled_result, result.scaled_result);
                        mismatches++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                nxt = run_sum + group_sum(item);
                if (item.last)
                begin
                    want.dot_sum       = nxt;
                    want.scaled_result = scale_sum(nxt, item.bias_value);
                    // Typed-in rows replace the prediction; the result is checked against the typed value
                    if (pin_use)
                        want = pin_res;
                    sums_due.push_back(want);
                    run_sum = '0;
                end
                else
                    run_sum = nxt;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : sink
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // Start the long hold once the sender switches to one-item vectors,
            // so the pipeline fills and item_ready must drop.
            if (burst_on && !held)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                hold--;
            end
            else if (quiet)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(99) >= 7);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic plan_row_t row(logic [31:0] scale, logic bias_on, logic [7:0] wb,
                                      int a, int b, int c, int d, logic [31:0] bias,
                                      logic last, bit pin, int dsum, longint sres);
        plan_row_t r;
        r.scale               = scale;
        r.bias_on             = bias_on;
        r.it.weight_byte      = wb;
        r.it.act_a            = a[7:0];
        r.it.act_b            = b[7:0];
        r.it.act_c            = c[7:0];
        r.it.act_d            = d[7:0];
        r.it.bias_value       = bias;
        r.it.last             = last;
        r.pinned              = pin;
        r.res.dot_sum         = dsum;
        r.res.scaled_result   = sres;
        return r;
    endfunction

    // Activations lean on the extremes now and then.
    function automatic logic [7:0] rand_act();
        case ($urandom_range(7))
            0:       return 8'h80;
            1:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic item_t rand_item(logic last);
        item_t it;
        it.weight_byte = 8'($urandom);
        it.act_a       = rand_act();
        it.act_b       = rand_act();
        it.act_c       = rand_act();
        it.act_d       = rand_act();
        case ($urandom_range(9))
            0:       it.bias_value = 32'h8000_0000;
            1:       it.bias_value = 32'h7FFF_FFFF;
            default: it.bias_value = $urandom;
        endcase
        it.last = last;
        return it;
    endfunction

    // Offer one item, with an occasional gap first; hold until accepted.
    task automatic send_item(item_t it, bit pin, result_t pinned);
        if (!quiet && $urandom_range(99) < 7)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item       <= it;
        pin_use    <= pin;
        pin_res    <= pinned;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        sent++;
    endtask

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            send_item(rand_item(i == len - 1), 1'b0, '0);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe drain.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sums_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(logic reg_sel, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata at 0x%0h: expected 0x%08h, got 0x%08h", {reg_sel, 2'b00},
                   want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write both registers, mirror them into the predictor, read them back.
    task automatic program_regs(logic [31:0] scale, logic bias_on);
        apb_write(REG_SCALE, scale);
        cfg_scale = scale;
        apb_write(REG_BIAS_EN, {31'b0, bias_on});
        cfg_bias_on = bias_on;
        apb_check(REG_SCALE, scale);
        apb_check(REG_BIAS_EN, {31'b0, bias_on});
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        plan_row_t   plan[$];
        logic [31:0] scale;
        int          goal;
        int          phase;

        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        pin_use     <= 1'b0;
        pin_res     <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        run_sum     = '0;
        cfg_scale   = SCALE_RESET;
        cfg_bias_on = 1'b0;
        mismatches  = 0;
        sent        = 0;
        quiet       = 1'b0;
        burst_on    = 1'b0;

        // Directed plan. Typed results follow straight from the definition;
        // the multi-item vectors are left to the predictor.
        // Reset setting: scale 1.0, bias off.
        plan.push_back(row(SCALE_RESET, 0, 8'h55, 127, 127, 127, 127, 0, 1, 1, 0, 0));
        plan.push_back(row(SCALE_RESET, 0, 8'h00, -128, -128, -128, -128, 0, 1, 1,
                           512, 64'sd512 * 64'sd65536));
        // all weights +2 (code three)
        plan.push_back(row(SCALE_RESET, 0, 8'hFF, 127, 127, 127, 127, 0, 1, 1,
                           1016, 64'sd1016 * 64'sd65536));
        plan.push_back(row(SCALE_RESET, 0, 8'hFF, -128, -128, -128, -128, 0, 1, 1,
                           -1024, -64'sd1024 * 64'sd65536));
        // bias field present but disabled: must be ignored
        plan.push_back(row(SCALE_RESET, 0, 8'hAA, -128, 127, -1, 1, 32'h7FFF_FFFF, 1, 1,
                           -1, -64'sd65536));
        plan.push_back(row(SCALE_RESET, 0, 8'hE4, 10, 20, 30, 40, 0, 0, 0, 0, 0));
        plan.push_back(row(SCALE_RESET, 0, 8'h1B, -5, -6, -7, -8, 0, 0, 0, 0, 0));
        plan.push_back(row(SCALE_RESET, 0, 8'h39, 100, -100, 50, -50, 0, 1, 0, 0, 0));
        // Largest scale, bias on, bias at both extremes.
        plan.push_back(row(32'hFFFF_FFFF, 1, 8'hFF, 127, 127, 127, 127, 32'h7FFF_FFFF, 1, 1,
                           1016, 64'sd1016 * 64'sd4294967295 + 64'sd2147483647));
        plan.push_back(row(32'hFFFF_FFFF, 1, 8'h00, 127, 127, 127, 127, 32'h8000_0000, 1, 1,
                           -508, -64'sd508 * 64'sd4294967295 - 64'sd2147483648));
        plan.push_back(row(32'hFFFF_FFFF, 1, 8'h55, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, -1));
        plan.push_back(row(32'hFFFF_FFFF, 1, 8'hC3, 7, -9, 100, -128, 0, 0, 0, 0, 0));
        plan.push_back(row(32'hFFFF_FFFF, 1, 8'h5A, -128, 127, 3, -3, 0, 0, 0, 0, 0));
        plan.push_back(row(32'hFFFF_FFFF, 1, 8'hF0, 127, -128, 9, 9, 12345, 1, 0, 0, 0));
        // Zero scale: only the bias is left.
        plan.push_back(row(32'h0, 1, 8'hAA, 5, 5, 5, 5, -7, 1, 1, 20, -7));
        plan.push_back(row(32'h0, 1, 8'hFF, -128, -128, -128, -128, 32'h7FFF_FFFF, 1, 1,
                           -1024, 2147483647));
        // Smallest nonzero scale, bias off.
        plan.push_back(row(32'h1, 0, 8'h00, -128, -128, -128, -128, 32'hFFFF_FFFF, 1, 1,
                           512, 512));
        plan.push_back(row(32'h1, 0, 8'hFF, -128, -128, -128, -128, 0, 1, 1, -1024, -1024));
        plan.push_back(row(SCALE_RESET, 1, 8'h96, 1, 2, 3, 4, 0, 0, 0, 0, 0));
        plan.push_back(row(SCALE_RESET, 1, 8'h69, -1, -2, -3, -4, 32'h0001_8000, 1, 0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first.
        apb_check(REG_SCALE, SCALE_RESET);
        apb_check(REG_BIAS_EN, 32'h0);

        // Walk the plan; reprogram only between vectors, with the block idle.
        foreach (plan[i])
        begin
            if (plan[i].scale != cfg_scale || plan[i].bias_on != cfg_bias_on)
            begin
                settle();
                program_regs(plan[i].scale, plan[i].bias_on);
            end
            send_item(plan[i].it, plan[i].pinned, plan[i].res);
        end
        settle();

        // Random phases: fresh setting each time, extremes favored.
        goal  = sent + RANDOM_ITEMS;
        phase = 0;
        while (sent < goal)
        begin
            case ($urandom_range(5))
                0:       scale = 32'h0;
                1:       scale = 32'hFFFF_FFFF;
                2:       scale = SCALE_RESET;
                3:       scale = 32'h1;
                default: scale = $urandom;
            endcase
            program_regs(scale, 1'($urandom_range(1)));
            if (phase == 2)
                quiet = 1'b1;
            if (phase == 4)
            begin
                // Every item closes a vector while the sink holds off.
                burst_on = 1'b1;
                repeat (60) send_vector(1);
            end
            else
            begin
                repeat ($urandom_range(3, 12))
                    send_vector(($urandom_range(9) < 8) ? $urandom_range(1, 6)
                                                        : $urandom_range(7, 40));
            end
            quiet = 1'b0;
            settle();
            phase++;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ternary_weight_dot_product_top test passed");
        else
            $display("ternary_weight_dot_product_top test failed");
        $finish;
    end

    // Generous fixed limit; the slowest legal run stays far below it.
    initial
    begin : watchdog
        #3_000_000;
        $display("ternary_weight_dot_product_top test failed");
        $finish;
    end

endmodule
